### hdl/bis_pkg.sv
// Shared types and constants for the bilinear image sampler.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
`timescale 1ns / 1ps

package bis_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int FRAC_BITS  = 8;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int SIZE_W  = 9;
	localparam int PIX_W   = 16;
	localparam int POS_W   = 16;
	localparam int VAL_W   = 24;
	localparam int GRAD_W  = 25;
	localparam int IN_W    = 64;
	localparam int OUT_W   = 80;

	localparam int NUM_READS = 4;
	localparam int IDX_W     = $clog2(NUM_READS);
	localparam logic [IDX_W-1:0] RD_LAST = IDX_W'(NUM_READS - 1);

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_VALUE  = 2'd1,
		CMD_GRAD   = 2'd2,
		CMD_CENTRE = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_WRITTEN = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_READ,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             latch;
		logic             setup;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic direct;
	} dp_stat_t;

endpackage

### hdl/bis_ctrl.sv
// Controller state machine for the bilinear image sampler.
// Sequences setup, the four store reads of an in-range query and result hand-off; depends on bis_pkg.
`timescale 1ns / 1ps

module bis_ctrl import bis_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		ctl.latch    = 1'b0;
		ctl.setup    = 1'b0;
		ctl.rd_en    = 1'b0;
		ctl.rd_idx   = cnt_q;
		ctl.out_load = 1'b0;
		s_tready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready  = 1'b1;
				ctl.latch = s_tvalid;
				if (s_tvalid) state_d = S_SETUP;
			end
			S_SETUP: begin
				ctl.setup = 1'b1;
				cnt_d     = '0;
				state_d   = stat.direct ? S_DONE : S_READ;
			end
			S_READ: begin
				ctl.rd_en = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == RD_LAST) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		if (ctl.out_load) out_valid_d = 1'b1;
		else if (m_tready) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	assign m_tvalid = out_valid_q;

endmodule

### hdl/bis_datapath.sv
// Datapath for the bilinear image sampler: size registers, pixel store,
// address and weight generation, multiply-accumulate and result register; depends on bis_pkg.
`timescale 1ns / 1ps

module bis_datapath import bis_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic [IN_W-1:0]   in_data,
	input  logic [1:0]        in_cmd,
	input  ctl_cmd_t          ctl,
	output dp_stat_t          stat,
	output logic [OUT_W-1:0]  out_data,
	output logic [1:0]        out_status
);

	localparam logic [FRAC_BITS:0] ONE_FIX  = (FRAC_BITS+1)'(1 << FRAC_BITS);
	localparam logic [FRAC_BITS:0] HALF_FIX = (FRAC_BITS+1)'(1 << (FRAC_BITS - 1));
	localparam int CV_W  = 2 * FRAC_BITS + 1;
	localparam int CG_W  = FRAC_BITS + 2;
	localparam int ACC_W = VAL_W + FRAC_BITS;

	logic [SIZE_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(MAX_WIDTH);
			height_q <= SIZE_W'(MAX_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp sizes to 2..MAX
	logic [SIZE_W-1:0] w_eff, h_eff;
	logic [COL_W-1:0]  wm1, wm2;
	logic [ROW_W-1:0]  hm1, hm2;

	always_comb begin
		if (width_q < SIZE_W'(2)) w_eff = SIZE_W'(2);
		else if (width_q > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
		else w_eff = width_q;
		if (height_q < SIZE_W'(2)) h_eff = SIZE_W'(2);
		else if (height_q > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
		else h_eff = height_q;
		wm1 = COL_W'(w_eff - SIZE_W'(1));
		wm2 = COL_W'(w_eff - SIZE_W'(2));
		hm1 = ROW_W'(h_eff - SIZE_W'(1));
		hm2 = ROW_W'(h_eff - SIZE_W'(2));
	end

	// item registers
	cmd_code_t          cmd_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [PIX_W-1:0]   pv_q;
	logic [POS_W-1:0]   xp_q, yp_q;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd_code_t'(in_cmd);
			col_q <= in_data[7:0];
			row_q <= in_data[15:8];
			pv_q  <= in_data[31:16];
			xp_q  <= in_data[47:32];
			yp_q  <= in_data[63:48];
		end
	end

	logic [COL_W-1:0]     ix;
	logic [ROW_W-1:0]     iy;
	logic [FRAC_BITS-1:0] sx, sy;
	logic [FRAC_BITS:0]   osx, osy;

	assign ix  = xp_q[POS_W-1:FRAC_BITS];
	assign iy  = yp_q[POS_W-1:FRAC_BITS];
	assign sx  = xp_q[FRAC_BITS-1:0];
	assign sy  = yp_q[FRAC_BITS-1:0];
	assign osx = ONE_FIX - {1'b0, sx};
	assign osy = ONE_FIX - {1'b0, sy};

	// range checks
	logic ok;

	always_comb begin
		case (cmd_q)
			CMD_VALUE:  ok = (xp_q <= {wm1, {FRAC_BITS{1'b0}}})
				&& (yp_q <= {hm1, {FRAC_BITS{1'b0}}});
			CMD_GRAD:   ok = (ix <= wm2) && (iy <= hm2);
			CMD_CENTRE: ok = ({1'b0, col_q} < w_eff) && ({1'b0, row_q} < h_eff);
			default:    ok = 1'b1;
		endcase
		stat.direct = (cmd_q == CMD_WRITE) || !ok;
	end

	// centre-gradient neighbors, one-sided at the edges
	logic [COL_W-1:0]  xl, xr;
	logic [ROW_W-1:0]  yu, yd;
	logic [FRAC_BITS:0] kx, ky;

	always_comb begin
		if (col_q == '0) begin
			xl = '0;
			xr = COL_W'(1);
		end else if (col_q == wm1) begin
			xl = col_q - 1'b1;
			xr = col_q;
		end else begin
			xl = col_q - 1'b1;
			xr = col_q + 1'b1;
		end
		if (row_q == '0) begin
			yu = '0;
			yd = ROW_W'(1);
		end else if (row_q == hm1) begin
			yu = row_q - 1'b1;
			yd = row_q;
		end else begin
			yu = row_q - 1'b1;
			yd = row_q + 1'b1;
		end
		kx = (col_q == '0 || col_q == wm1) ? ONE_FIX : HALF_FIX;
		ky = (row_q == '0 || row_q == hm1) ? ONE_FIX : HALF_FIX;
	end

	// address and coefficients of the current read
	logic [COL_W-1:0]        col1, rd_col;
	logic [ROW_W-1:0]        row1, rd_row;
	logic [FRAC_BITS:0]      fa, fb, mag_x, mag_y;
	logic signed [CG_W-1:0]  cgx, cgy;

	always_comb begin
		col1 = (cmd_q == CMD_VALUE && sx == '0) ? ix : ix + 1'b1;
		row1 = (cmd_q == CMD_VALUE && sy == '0) ? iy : iy + 1'b1;
		rd_col = ctl.rd_idx[0] ? col1 : ix;
		rd_row = ctl.rd_idx[1] ? row1 : iy;
		fa     = '0;
		fb     = '0;
		cgx    = '0;
		cgy    = '0;
		mag_x  = ctl.rd_idx[1] ? {1'b0, sy} : osy;
		mag_y  = ctl.rd_idx[0] ? {1'b0, sx} : osx;
		case (cmd_q)
			CMD_VALUE: begin
				fa = ctl.rd_idx[0] ? {1'b0, sx} : osx;
				fb = ctl.rd_idx[1] ? {1'b0, sy} : osy;
			end
			CMD_GRAD: begin
				cgx = ctl.rd_idx[0] ? $signed({1'b0, mag_x}) : -$signed({1'b0, mag_x});
				cgy = ctl.rd_idx[1] ? $signed({1'b0, mag_y}) : -$signed({1'b0, mag_y});
			end
			CMD_CENTRE: begin
				case (ctl.rd_idx)
					2'd0: begin
						rd_row = row_q;
						rd_col = xl;
						cgx    = -$signed({1'b0, kx});
					end
					2'd1: begin
						rd_row = row_q;
						rd_col = xr;
						cgx    = $signed({1'b0, kx});
					end
					2'd2: begin
						rd_row = yu;
						rd_col = col_q;
						cgy    = -$signed({1'b0, ky});
					end
					default: begin
						rd_row = yd;
						rd_col = col_q;
						cgy    = $signed({1'b0, ky});
					end
				endcase
			end
			default: ;
		endcase
	end

	// pixel store, single port
	logic [PIX_W-1:0]        mem [0:(1 << ADDR_W)-1];
	logic signed [PIX_W-1:0] rdata_s1;
	logic                    mem_we;

	assign mem_we = ctl.setup && (cmd_q == CMD_WRITE);

	always_ff @(posedge clk) begin
		if (mem_we) mem[{row_q, col_q}] <= pv_q;
		if (ctl.rd_en) rdata_s1 <= $signed(mem[{rd_row, rd_col}]);
	end

	logic [CV_W-1:0]        cv_s1;
	logic signed [CG_W-1:0] cgx_s1, cgy_s1;
	logic                   acc_en_s1;

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			cv_s1  <= CV_W'(fa) * CV_W'(fb);
			cgx_s1 <= cgx;
			cgy_s1 <= cgy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_en_s1 <= 1'b0;
		else acc_en_s1 <= ctl.rd_en;
	end

	// accumulate modulo the result widths
	logic signed [PIX_W+CV_W:0]   prod_v;
	logic signed [PIX_W+CG_W-1:0] prod_x, prod_y;
	logic [ACC_W-1:0]             acc_v_q;
	logic [GRAD_W-1:0]            acc_x_q, acc_y_q;
	status_t                      status_q;

	assign prod_v = (PIX_W+CV_W+1)'(rdata_s1) * (PIX_W+CV_W+1)'($signed({1'b0, cv_s1}));
	assign prod_x = (PIX_W+CG_W)'(rdata_s1) * (PIX_W+CG_W)'(cgx_s1);
	assign prod_y = (PIX_W+CG_W)'(rdata_s1) * (PIX_W+CG_W)'(cgy_s1);

	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			acc_v_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			if (cmd_q == CMD_WRITE) status_q <= ST_WRITTEN;
			else if (ok) status_q <= ST_DONE;
			else status_q <= ST_RANGE;
		end else if (acc_en_s1) begin
			acc_v_q <= acc_v_q + prod_v[ACC_W-1:0];
			acc_x_q <= acc_x_q + prod_x[GRAD_W-1:0];
			acc_y_q <= acc_y_q + prod_y[GRAD_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_status <= status_q;
			out_data   <= {{(OUT_W - VAL_W - 2*GRAD_W){1'b0}}, acc_y_q, acc_x_q,
				acc_v_q[ACC_W-1:FRAC_BITS]};
		end
	end

endmodule

### hdl/bilinear_image_sampler_core.sv
// Bilinear image sampler: pixel store with value, gradient and centre-gradient queries.
// A write or out-of-range item goes through the setup and done states into the output
// register; a query also makes four reads of the single-port pixel store and a drain.
// A new item is accepted only once the last one is loaded into the output register.
// Reset (arst_n, async, low) clears control and sets both sizes to 256; the store
// keeps no reset and must be written before it is read.
`timescale 1ns / 1ps

module bilinear_image_sampler_core import bis_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	// pixel_col[7:0], pixel_row[15:8], pixel_value[31:16], x_pos[47:32], y_pos[63:48]
	input  logic [IN_W-1:0]   s_tdata,
	// command[1:0]
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// sample_value[23:0], grad_x[48:24], grad_y[73:49], zero fill above
	output logic [OUT_W-1:0]  m_tdata,
	// status[1:0]
	output logic [1:0]        m_tuser
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	bis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	bis_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_data    (s_tdata),
		.in_cmd     (s_tuser),
		.ctl        (ctl),
		.stat       (stat),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

endmodule

### hdl/bis_checker.sv
// Port-level checks for the bilinear image sampler, bound to the top level.
// Depends on bis_pkg and bilinear_image_sampler_core.
`timescale 1ns / 1ps

module bis_checker import bis_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [1:0]       s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [1:0]       m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == ST_DONE || m_tuser == ST_WRITTEN || m_tuser == ST_RANGE)
		else $error("undefined status code");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_DONE |-> m_tdata == '0)
		else $error("nonzero payload on write or range result");

	a_write_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_WRITE |=> ##1 !s_tready)
		else $error("write item finished too early");

endmodule

bind bilinear_image_sampler_core bis_checker u_bis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
